// File: rtl/udiv_pkg.sv
// Shared types and constants for the 256-bit unsigned divider.
// Used by the channel interfaces, udiv_core and unsigned_divide_256_unit.
package udiv_pkg;

    localparam int WORD_BITS = 64;
    localparam int WIDE_BITS = 256;
    localparam int CNT_BITS  = 8;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WIDE_BITS-1:0] wide_t;

    typedef struct packed {
        logic start;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

// File: rtl/udiv_req_if.sv
// Request channel of the divider: dividend and divisor as four words each.
// Depends on udiv_pkg for the word type.
interface udiv_req_if;

    logic           valid;
    logic           ready;
    udiv_pkg::word_t dividend_w0;
    udiv_pkg::word_t dividend_w1;
    udiv_pkg::word_t dividend_w2;
    udiv_pkg::word_t dividend_w3;
    udiv_pkg::word_t divisor_w0;
    udiv_pkg::word_t divisor_w1;
    udiv_pkg::word_t divisor_w2;
    udiv_pkg::word_t divisor_w3;

    modport source (
        output valid, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
        output divisor_w0, divisor_w1, divisor_w2, divisor_w3,
        input  ready
    );

    modport sink (
        input  valid, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
        input  divisor_w0, divisor_w1, divisor_w2, divisor_w3,
        output ready
    );

endinterface

// File: rtl/udiv_rsp_if.sv
// Response channel of the divider: quotient, remainder and the zero-divisor flag.
// Depends on udiv_pkg for the word type.
interface udiv_rsp_if;

    logic           valid;
    logic           ready;
    udiv_pkg::word_t quotient_w0;
    udiv_pkg::word_t quotient_w1;
    udiv_pkg::word_t quotient_w2;
    udiv_pkg::word_t quotient_w3;
    udiv_pkg::word_t remainder_w0;
    udiv_pkg::word_t remainder_w1;
    udiv_pkg::word_t remainder_w2;
    udiv_pkg::word_t remainder_w3;
    logic           divide_by_zero;

    modport source (
        output valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
        output remainder_w0, remainder_w1, remainder_w2, remainder_w3,
        output divide_by_zero,
        input  ready
    );

    modport sink (
        input  valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
        input  remainder_w0, remainder_w1, remainder_w2, remainder_w3,
        input  divide_by_zero,
        output ready
    );

endinterface

// File: rtl/udiv_core.sv
// Restoring radix-2 divide engine: one shared 257-bit subtract per cycle.
// Depends on udiv_pkg; instantiated by unsigned_divide_256_unit.
module udiv_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  udiv_pkg::core_ctrl_t ctrl,
    input  udiv_pkg::wide_t      num,
    input  udiv_pkg::wide_t      den,
    output udiv_pkg::core_stat_t stat,
    output udiv_pkg::wide_t      quo,
    output udiv_pkg::wide_t      rem
);
    import udiv_pkg::*;

    wide_t               qn_reg;
    wide_t               rem_reg;
    wide_t               den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;

    logic [WIDE_BITS:0]   shifted;
    logic [WIDE_BITS+1:0] trial;
    logic                 take;
    logic                 last;

    assign shifted = {rem_reg, qn_reg[WIDE_BITS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign take    = !trial[WIDE_BITS+1];
    assign last    = (cnt_reg == CNT_BITS'(WIDE_BITS - 1));

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            qn_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            qn_reg  <= {qn_reg[WIDE_BITS-2:0], take};
            rem_reg <= take ? trial[WIDE_BITS-1:0] : shifted[WIDE_BITS-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = qn_reg;
    assign rem       = rem_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> busy_reg)
        else $error("Engine did not go busy after start.");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && $past(last) && !busy_reg)
        else $error("Done raised without a final step.");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < den_reg))
        else $error("Final remainder is not below the divisor.");

endmodule

// File: rtl/unsigned_divide_256_unit.sv
// Top level of the 256-bit unsigned divider with request and response channels.
// Depends on udiv_pkg, udiv_req_if, udiv_rsp_if and udiv_core.
//
// The unit divides a 256-bit unsigned dividend by a 256-bit unsigned divisor and
// returns the exact quotient and remainder. It takes one request at a time: ready is
// high only while the unit is idle. A normal division runs in the engine, one quotient
// bit per cycle through a single 257-bit subtract; the result is registered and held
// on the response channel until it is taken, and the unit is ready again in the cycle
// after the response is taken. A zero dividend returns zeros, and a zero divisor
// with a nonzero dividend returns zeros with divide_by_zero set; both skip the engine
// and respond on the next cycle.
module unsigned_divide_256_unit (
    input  logic         clk,
    input  logic         rst_n,
    udiv_req_if.sink     req,
    udiv_rsp_if.source   rsp
);
    import udiv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    wide_t      num_in;
    wide_t      den_in;
    logic       accept;
    logic       num_zero;
    logic       den_zero;

    core_ctrl_t core_ctrl;
    core_stat_t core_stat;
    wide_t      core_quo;
    wide_t      core_rem;

    wide_t      quo_reg;
    wide_t      rem_reg;
    logic       dz_reg;

    assign num_in   = {req.dividend_w3, req.dividend_w2, req.dividend_w1, req.dividend_w0};
    assign den_in   = {req.divisor_w3, req.divisor_w2, req.divisor_w1, req.divisor_w0};
    assign num_zero = (num_in == '0);
    assign den_zero = (den_in == '0);
    assign req.ready = (state_reg == ST_IDLE);
    assign accept   = req.valid && req.ready;

    assign core_ctrl.start = accept && !num_zero && !den_zero;

    udiv_core u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (core_ctrl),
        .num  (num_in),
        .den  (den_in),
        .stat (core_stat),
        .quo  (core_quo),
        .rem  (core_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = core_ctrl.start ? ST_RUN : ST_OUT;
                end
            end
            ST_RUN:
            begin
                if (core_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !core_ctrl.start)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            dz_reg  <= !num_zero;
        end
        else if (state_reg == ST_RUN && core_stat.done)
        begin
            quo_reg <= core_quo;
            rem_reg <= core_rem;
            dz_reg  <= 1'b0;
        end
    end

    assign rsp.valid          = (state_reg == ST_OUT);
    assign rsp.quotient_w0    = quo_reg[WORD_BITS-1:0];
    assign rsp.quotient_w1    = quo_reg[2*WORD_BITS-1:WORD_BITS];
    assign rsp.quotient_w2    = quo_reg[3*WORD_BITS-1:2*WORD_BITS];
    assign rsp.quotient_w3    = quo_reg[4*WORD_BITS-1:3*WORD_BITS];
    assign rsp.remainder_w0   = rem_reg[WORD_BITS-1:0];
    assign rsp.remainder_w1   = rem_reg[2*WORD_BITS-1:WORD_BITS];
    assign rsp.remainder_w2   = rem_reg[3*WORD_BITS-1:2*WORD_BITS];
    assign rsp.remainder_w3   = rem_reg[4*WORD_BITS-1:3*WORD_BITS];
    assign rsp.divide_by_zero = dz_reg;

    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && core_stat.busy))
        else $error("Request port is ready while the engine is busy.");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> (state_reg == ST_RUN))
        else $error("Engine finished outside the run state.");

    a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.divide_by_zero) |-> (quo_reg == '0 && rem_reg == '0))
        else $error("Divide-by-zero response carries a nonzero result.");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("Unit took a second request before responding.");

endmodule

// File: sim/tb_unsigned_divide_256_unit.sv
`timescale 1ns / 1ps
// Testbench for unsigned_divide_256_unit: drives division requests with random gaps and
// stalls, and checks each response against an exact 256-bit quotient and remainder.
// Depends on udiv_pkg, udiv_req_if, udiv_rsp_if and the RTL of the unit.
module tb_unsigned_divide_256_unit;

    import udiv_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 780;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        wide_t quotient;
        wide_t remainder;
        logic  divide_by_zero;
    } division_t;

    class divide_scoreboard;
        division_t awaited[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_request(wide_t dividend, wide_t divisor);
            division_t want;
            want.quotient       = '0;
            want.remainder      = '0;
            want.divide_by_zero = 1'b0;
            if (dividend != '0)
            begin
                if (divisor == '0)
                begin
                    want.divide_by_zero = 1'b1;
                end
                else
                begin
                    want.quotient  = dividend / divisor;
                    want.remainder = dividend % divisor;
                end
            end
            awaited.push_back(want);
        endfunction

        function void check_response(division_t got);
            division_t want;
            int        w;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: response with no request waiting: q=%h r=%h dz=%b",
                             $time, got.quotient, got.remainder, got.divide_by_zero);
                return;
            end
            want = awaited.pop_front();
            for (w = 0; w < 4; w++)
            begin
                if (got.quotient[64*w +: 64] !== want.quotient[64*w +: 64])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: quotient_w%0d expected %h got %h", $time, w,
                                 want.quotient[64*w +: 64], got.quotient[64*w +: 64]);
                end
                if (got.remainder[64*w +: 64] !== want.remainder[64*w +: 64])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: remainder_w%0d expected %h got %h", $time, w,
                                 want.remainder[64*w +: 64], got.remainder[64*w +: 64]);
                end
            end
            if (got.divide_by_zero !== want.divide_by_zero)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: divide_by_zero expected %b got %b", $time,
                             want.divide_by_zero, got.divide_by_zero);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int failures();
            return mismatches + awaited.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    udiv_req_if req();
    udiv_rsp_if rsp();

    unsigned_divide_256_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    divide_scoreboard book;
    bit               steady;
    int               quiet_cycles;
    int               stall_left;

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 300);
    endfunction

    function automatic wide_t random_operand();
        wide_t value;
        int    i;
        int    span;
        int    kind;
        for (i = 0; i < 8; i++)
            value[32*i +: 32] = $urandom;
        kind = $urandom_range(0, 9);
        span = $urandom_range(1, 256);
        if (kind == 0)
            value = '1;
        else if (kind == 1)
            value = wide_t'(1) << (span - 1);
        else if (kind == 2 && span < 256)
            value = (wide_t'(1) << span) - 1;
        else if (span < 256)
            value = value & ((wide_t'(1) << span) - 1);
        return value;
    endfunction

    task automatic send_request(wide_t dividend, wide_t divisor);
        int gap;
        req.valid <= 1'b1;
        {req.dividend_w3, req.dividend_w2, req.dividend_w1, req.dividend_w0} <= dividend;
        {req.divisor_w3, req.divisor_w2, req.divisor_w1, req.divisor_w0} <= divisor;
        do
            @(posedge clk);
        while (!req.ready);
        book.note_request(dividend, divisor);
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            book.check_response({rsp.quotient_w3, rsp.quotient_w2, rsp.quotient_w1,
                                 rsp.quotient_w0, rsp.remainder_w3, rsp.remainder_w2,
                                 rsp.remainder_w1, rsp.remainder_w0, rsp.divide_by_zero});
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            stall_left = pick_gap();
            rsp.ready <= (stall_left == 0);
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        wide_t dividend;
        wide_t divisor;
        wide_t swap;
        int    n;
        int    roll;

        book         = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        steady       = 1'b0;
        quiet_cycles = 0;
        stall_left   = 0;
        req.valid    = 1'b0;
        {req.dividend_w3, req.dividend_w2, req.dividend_w1, req.dividend_w0} = '0;
        {req.divisor_w3, req.divisor_w2, req.divisor_w1, req.divisor_w0} = '0;
        rsp.ready    = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Zero dividend, zero divisor, and the word boundaries of both operands.
        send_request('0, '0);
        send_request('0, '1);
        send_request('1, '0);
        send_request(256'd1, '0);
        send_request(wide_t'(1) << 200, '0);
        send_request('1, '1);
        send_request('1, 256'd1);
        send_request(256'd1, 256'd1);
        send_request(256'd1, '1);
        send_request('1, 256'd2);
        send_request(wide_t'(1) << 255, 256'd3);
        send_request(wide_t'(1) << 255, (wide_t'(1) << 255) - 1);
        send_request((wide_t'(1) << 255) - 1, wide_t'(1) << 255);
        send_request('1, (wide_t'(1) << 128) + 1);
        send_request('1, wide_t'(1) << 64);
        send_request(wide_t'(1) << 192, wide_t'(1) << 64);
        send_request('1, wide_t'(1) << 255);
        send_request(256'd100, 256'd7);
        send_request({4{64'h8000_0000_0000_0001}}, 256'hffff_ffff_ffff_ffff);
        dividend = random_operand();
        send_request(dividend, dividend | 256'd1);
        send_request({4{64'hffff_ffff_ffff_ffff}}, {64'd0, 64'd0, 64'd1, 64'hffff_ffff});

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            roll     = $urandom_range(0, 99);
            dividend = random_operand();
            divisor  = random_operand();
            if (roll < 6)
            begin
                dividend = '0;
                if (roll < 3)
                    divisor = '0;
            end
            else if (roll < 12)
            begin
                divisor = '0;
                if (dividend == '0)
                    dividend = '1;
            end
            else if (roll < 16)
            begin
                divisor = dividend;
            end
            else if (roll < 24 && divisor < dividend)
            begin
                swap     = dividend;
                dividend = divisor;
                divisor  = swap;
            end
            else if (roll >= 24 && roll < 60)
            begin
                divisor = divisor >> $urandom_range(0, 255);
            end
            send_request(dividend, divisor);
        end
        req.valid <= 1'b0;
        steady = 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.failures() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
